// File: sv/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

	// Default number of stack entries.
	localparam int STACK_DEPTH_DEF = 16;

	// Word width of a Q16.16 value.
	localparam int DATA_W = 32;

	// Operation codes carried in the input tuser field.
	typedef logic [2:0] op_t;
	localparam op_t OP_PUSH = 3'd0;
	localparam op_t OP_ADD  = 3'd1;
	localparam op_t OP_SUB  = 3'd2;
	localparam op_t OP_MUL  = 3'd3;
	localparam op_t OP_DIV  = 3'd4;

	// Status codes given with each result item.
	typedef logic [2:0] status_t;
	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_UNDER = 3'd1;
	localparam status_t ST_OVER  = 3'd2;
	localparam status_t ST_DIVZ  = 3'd3;
	localparam status_t ST_SAT   = 3'd4;

	// Saturation limits of the signed 32-bit range.
	localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	// Response from the arithmetic unit.
	typedef struct packed {
		logic done;
		logic sat;
		logic divz;
	} alu_rsp_t;

endpackage

// File: sv/pse_stack.sv
`timescale 1ns / 1ps

module pse_stack #(
	parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [pse_pkg::DATA_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [pse_pkg::DATA_W-1:0] rd_data
);

	logic [pse_pkg::DATA_W-1:0] mem [DEPTH];
	logic [pse_pkg::DATA_W-1:0] rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/pse_alu.sv
`timescale 1ns / 1ps

module pse_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pse_pkg::alu_req_t          req,
	input  logic [pse_pkg::DATA_W-1:0] x,
	input  logic [pse_pkg::DATA_W-1:0] y,
	output pse_pkg::alu_rsp_t          rsp,
	output logic [pse_pkg::DATA_W-1:0] result
);

	localparam logic [5:0] MUL_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS = 6'd48;

	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic        is_div_q;
	logic        neg_q;
	logic        sat_q;
	logic        divz_q;
	logic [5:0]  cnt_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q;
	logic [31:0] mcand_q;
	logic [31:0] result_q;

	logic [31:0] x_mag;
	logic [31:0] y_mag;
	logic [32:0] add_a;
	logic [32:0] add_b;
	logic        add_sub;
	logic [32:0] add_sum;
	logic        add_ovf;
	logic [31:0] add_res;
	logic [47:0] mag;
	logic [31:0] fin_res;
	logic        fin_sat;
	logic [31:0] divz_res;

	// Magnitudes of the operands; the smallest value maps to 2^31.
	assign x_mag = x[31] ? (~x + 32'd1) : x;
	assign y_mag = y[31] ? (~y + 32'd1) : y;

	// Operand selection for the one shared 33-bit adder.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		if (busy_q && !is_div_q) begin
			add_a = {1'b0, prod_q[63:32]};
			add_b = {1'b0, mcand_q};
		end else if (busy_q) begin
			add_a   = {rem_q, prod_q[47]};
			add_b   = {1'b0, mcand_q};
			add_sub = 1'b1;
		end else begin
			add_a   = {x[31], x};
			add_b   = {y[31], y};
			add_sub = (req.op == pse_pkg::OP_SUB);
		end
	end

	assign add_sum = add_a + (add_b ^ {33{add_sub}}) + {32'd0, add_sub};

	// Saturated sum or difference.
	assign add_ovf = add_sum[32] ^ add_sum[31];
	assign add_res = add_ovf ? (add_sum[32] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX)
	                         : add_sum[31:0];

	// Final magnitude, sign and saturation of a product or quotient.
	assign mag = is_div_q ? prod_q[47:0] : prod_q[63:16];

	always_comb begin
		fin_res = mag[31:0];
		fin_sat = 1'b0;
		if (neg_q) begin
			if (mag > 48'h0000_8000_0000) begin
				fin_res = pse_pkg::VAL_MIN;
				fin_sat = 1'b1;
			end else begin
				fin_res = 32'd0 - mag[31:0];
			end
		end else if (mag > 48'h0000_7FFF_FFFF) begin
			fin_res = pse_pkg::VAL_MAX;
			fin_sat = 1'b1;
		end
	end

	// Result of a division by zero follows the sign of the dividend.
	assign divz_res = (x == '0) ? '0 : (x[31] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX);

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (req.start) begin
				case (req.op)
					pse_pkg::OP_MUL: begin
						busy_q <= 1'b1;
						done_q <= 1'b0;
					end
					pse_pkg::OP_DIV: begin
						busy_q <= (y != '0);
						done_q <= (y == '0);
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				done_q <= 1'b0;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Datapath: shift-add multiply and restoring divide on magnitudes.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q    <= x[31] ^ y[31];
			is_div_q <= (req.op == pse_pkg::OP_DIV);
			rem_q    <= '0;
			case (req.op)
				pse_pkg::OP_MUL: begin
					mcand_q <= x_mag;
					prod_q  <= {32'd0, y_mag};
					cnt_q   <= MUL_STEPS;
					sat_q   <= 1'b0;
					divz_q  <= 1'b0;
				end
				pse_pkg::OP_DIV: begin
					mcand_q <= y_mag;
					prod_q  <= {16'd0, x_mag, 16'd0};
					cnt_q   <= DIV_STEPS;
					sat_q   <= 1'b0;
					divz_q  <= (y == '0);
					if (y == '0) begin
						result_q <= divz_res;
					end
				end
				default: begin
					result_q <= add_res;
					sat_q    <= add_ovf;
					divz_q   <= 1'b0;
				end
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (!is_div_q) begin
				prod_q <= {(prod_q[0] ? add_sum : {1'b0, prod_q[63:32]}), prod_q[31:1]};
			end else begin
				rem_q  <= add_sum[32] ? add_a[31:0] : add_sum[31:0];
				prod_q <= {prod_q[62:0], ~add_sum[32]};
			end
		end else if (fin_q) begin
			result_q <= fin_res;
			sat_q    <= fin_sat;
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.divz = divz_q;
	assign result   = result_q;

endmodule

// File: sv/pse_ctrl.sv
`timescale 1ns / 1ps

module pse_ctrl #(
	parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [pse_pkg::DATA_W-1:0] s_tdata,
	input  logic                       s_tlast,
	input  logic [2:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [pse_pkg::DATA_W-1:0] m_tdata,
	output logic [2:0]                 m_tuser,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [pse_pkg::DATA_W-1:0] wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [pse_pkg::DATA_W-1:0] rd_data,
	output pse_pkg::alu_req_t          alu_req,
	output logic [pse_pkg::DATA_W-1:0] alu_x,
	output logic [pse_pkg::DATA_W-1:0] alu_y,
	input  pse_pkg::alu_rsp_t          alu_rsp,
	input  logic [pse_pkg::DATA_W-1:0] alu_result
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDX  = 6'b000010,
		S_RDY  = 6'b000100,
		S_RUN  = 6'b001000,
		S_TOP  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	pse_pkg::status_t           err_q;
	logic                       last_q;
	pse_pkg::op_t               op_q;
	logic [pse_pkg::DATA_W-1:0] x_q;
	logic                       m_tvalid_q;
	logic [pse_pkg::DATA_W-1:0] m_tdata_q;
	pse_pkg::status_t           m_tuser_q;

	logic          accept;
	logic          is_push;
	logic          is_arith;
	logic          has_room;
	logic          has_two;
	logic          has_one;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic          out_free;
	logic          wb;

	// Keeps the first error of an expression.
	function automatic pse_pkg::status_t note_err(pse_pkg::status_t cur,
	                                              pse_pkg::status_t code);
		return (cur == pse_pkg::ST_OK) ? code : cur;
	endfunction

	// Decode of the incoming item and of the stack fill.
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_push  = (s_tuser == pse_pkg::OP_PUSH);
	assign is_arith = (s_tuser inside {[pse_pkg::OP_ADD:pse_pkg::OP_DIV]});
	assign has_room = (count_q < CW'(DEPTH));
	assign has_two  = (count_q >= CW'(2));
	assign has_one  = (count_q != '0);
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign out_free = !m_tvalid_q || m_tready;
	assign wb       = (state_q == S_RUN) && alu_rsp.done;

	// Stack write port: pushes from the input, results from the unit.
	assign wr_en   = (accept && is_push && has_room) || wb;
	assign wr_addr = (state_q == S_RUN) ? cnt_m2[AW-1:0] : count_q[AW-1:0];
	assign wr_data = (state_q == S_RUN) ? alu_result : s_tdata;

	// Stack read port: top, then next entry, then top at expression end.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_m1[AW-1:0];
		case (state_q)
			S_IDLE: begin
				rd_en = accept && is_arith && has_two;
			end
			S_RDX: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m2[AW-1:0];
			end
			S_TOP: begin
				rd_en = has_one;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Start of the arithmetic unit once both operands are read.
	assign alu_req.start = (state_q == S_RDY);
	assign alu_req.op    = op_q;
	assign alu_x         = x_q;
	assign alu_y         = rd_data;

	// Sequencer, stack count, sticky status and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			err_q      <= pse_pkg::ST_OK;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						if (is_push) begin
							if (has_room) begin
								count_q <= count_q + CW'(1);
							end else begin
								err_q <= note_err(err_q, pse_pkg::ST_OVER);
							end
							state_q <= s_tlast ? S_TOP : S_IDLE;
						end else if (is_arith && has_two) begin
							state_q <= S_RDX;
						end else begin
							err_q   <= note_err(err_q, pse_pkg::ST_UNDER);
							state_q <= s_tlast ? S_TOP : S_IDLE;
						end
					end
				end
				S_RDX: begin
					state_q <= S_RDY;
				end
				S_RDY: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (alu_rsp.done) begin
						count_q <= cnt_m1;
						if (alu_rsp.divz) begin
							err_q <= note_err(err_q, pse_pkg::ST_DIVZ);
						end else if (alu_rsp.sat) begin
							err_q <= note_err(err_q, pse_pkg::ST_SAT);
						end
						state_q <= last_q ? S_TOP : S_IDLE;
					end
				end
				S_TOP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						count_q <= '0;
						err_q   <= pse_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: item operation, first operand, result item.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tuser;
		end
		if (state_q == S_RDX) begin
			x_q <= rd_data;
		end
		if (state_q == S_EMIT && out_free) begin
			m_tdata_q <= has_one ? rd_data : '0;
			m_tuser_q <= (err_q == pse_pkg::ST_OK && !has_one) ? pse_pkg::ST_UNDER : err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: sv/postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps

// Postfix expression evaluator over signed Q16.16 values.
// Input channel s_*: one item per token. tuser holds the operation (push, add,
// subtract, multiply, divide), tdata the value to push, tlast the final item of
// an expression. Output channel m_*: one item per expression, tdata the top of
// the stack and tuser the sticky status of the first error.
// Each input item is worked on alone and s_tready is low until it is done.
// A push is written to the stack memory as it is accepted. An operator reads its
// two operands from the stack memory one after the other and then runs the
// shared arithmetic unit: add, subtract and division by zero need no iteration,
// multiply runs 32 shift-add steps and divide 48 restoring steps. The last item of
// an expression then reads the top of the stack and loads the output register.
// The output register lets the next expression start while a result waits;
// if the receiver stalls, the next result holds the block in its final cycle.
// Reset empties the stack, clears the status and drops any pending result;
// the stack memory itself is not cleared.
module postfix_stack_evaluator_unit #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] operand_value
	input  logic        s_tlast,   // expr_end
	input  logic [2:0]  s_tuser,   // [2:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [pse_pkg::DATA_W-1:0] wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [pse_pkg::DATA_W-1:0] rd_data;
	pse_pkg::alu_req_t          alu_req;
	pse_pkg::alu_rsp_t          alu_rsp;
	logic [pse_pkg::DATA_W-1:0] alu_x;
	logic [pse_pkg::DATA_W-1:0] alu_y;
	logic [pse_pkg::DATA_W-1:0] alu_result;

	// Sequencer with stack pointer and status.
	pse_ctrl #(
		.DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.alu_req   (alu_req),
		.alu_x     (alu_x),
		.alu_y     (alu_y),
		.alu_rsp   (alu_rsp),
		.alu_result(alu_result)
	);

	// Stack storage.
	pse_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Shared arithmetic unit.
	pse_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.x     (alu_x),
		.y     (alu_y),
		.rsp   (alu_rsp),
		.result(alu_result)
	);

endmodule

// File: sv/pse_checker.sv
`timescale 1ns / 1ps

module pse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A stalled result item holds its value and status.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("stalled result item changed");

	// Status is always one of the defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= pse_pkg::ST_SAT)
	else $error("result status out of range");

	// An item that does not end an expression never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
	else $error("result produced by an item that is not last");

	// The last item of an expression keeps the input closed while it finishes.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
	else $error("input ready right after the last item");

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: bench/postfix_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the postfix evaluator, keeps its own model of the
// stack and the sticky status, and compares every result item in order.
module postfix_result_checker
	import pse_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] operand_value
	input  logic        s_tlast,   // expr_end
	input  logic [2:0]  s_tuser,   // [2:0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] result_value
	input  logic [2:0]  m_tuser,   // [2:0] status
	output int          fail_count,
	output int          results_pending,
	output int          tokens_seen,
	output int          results_checked
);

	// Signed 32-bit limits, widened for the 64-bit arithmetic.
	localparam longint WORD_MAX = longint'($signed(VAL_MAX));
	localparam longint WORD_MIN = longint'($signed(VAL_MIN));

	// Top of stack and status expected at the end of an expression.
	typedef struct packed {
		logic [31:0] top;
		status_t     status;
	} eval_result_t;

	eval_result_t expected_tops [$];
	logic [31:0]  stack_words [STACK_DEPTH];
	int           depth_used;
	status_t      first_error;

	// Only the first error of an expression is kept.
	function automatic void note_error(status_t code);
		if (first_error == ST_OK) begin
			first_error = code;
		end
	endfunction

	// Clamps a wide result to the signed 32-bit range.
	function automatic logic [31:0] clamp_word(longint v);
		if (v > WORD_MAX) begin
			note_error(ST_SAT);
			return VAL_MAX;
		end else if (v < WORD_MIN) begin
			note_error(ST_SAT);
			return VAL_MIN;
		end
		return v[31:0];
	endfunction

	// x is the old top of stack and y the entry beneath it.
	function automatic logic [31:0] combine(op_t op, longint x, longint y);
		longint r;
		case (op)
			OP_ADD: r = x + y;
			OP_SUB: r = x - y;
			OP_MUL: r = (x * y) / 65536;
			default: begin
				// Division by zero saturates towards the sign of x.
				if (y == 0) begin
					note_error(ST_DIVZ);
					if (x > 0) begin
						return VAL_MAX;
					end else if (x < 0) begin
						return VAL_MIN;
					end
					return '0;
				end
				r = (x * 65536) / y;
			end
		endcase
		return clamp_word(r);
	endfunction

	// Applies one accepted item to the model and queues a result on the last one.
	task automatic evaluate_token(op_t op, logic [31:0] value, logic last);
		longint       x;
		longint       y;
		eval_result_t res;
		if (op == OP_PUSH) begin
			if (depth_used >= STACK_DEPTH) begin
				note_error(ST_OVER);
			end else begin
				stack_words[depth_used] = value;
				depth_used++;
			end
		end else if (op > OP_DIV || depth_used < 2) begin
			// Unknown codes and operators short of operands leave the stack alone.
			note_error(ST_UNDER);
		end else begin
			x = longint'($signed(stack_words[depth_used-1]));
			y = longint'($signed(stack_words[depth_used-2]));
			depth_used -= 2;
			stack_words[depth_used] = combine(op, x, y);
			depth_used++;
		end
		if (last) begin
			res.status = first_error;
			if (depth_used >= 1) begin
				res.top = stack_words[depth_used-1];
			end else begin
				res.top = '0;
				if (first_error == ST_OK) begin
					res.status = ST_UNDER;
				end
			end
			expected_tops.push_back(res);
			depth_used  = 0;
			first_error = ST_OK;
		end
	endtask

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, seen, wanted);
		fail_count++;
	endtask

	// Results are compared before the item of the same edge is applied.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tops.delete();
			depth_used      = 0;
			first_error     = ST_OK;
			fail_count      = 0;
			tokens_seen     = 0;
			results_checked = 0;
			results_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_tops.size() == 0) begin
					report_mismatch("unexpected result item", m_tdata, '0);
				end else begin
					if (m_tdata !== expected_tops[0].top) begin
						report_mismatch("result_value", m_tdata, expected_tops[0].top);
					end
					if (m_tuser !== expected_tops[0].status) begin
						report_mismatch("status", 32'(m_tuser), 32'(expected_tops[0].status));
					end
					void'(expected_tops.pop_front());
					results_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				tokens_seen++;
				evaluate_token(op_t'(s_tuser), s_tdata, s_tlast);
			end
			results_pending <= expected_tops.size();
		end
	end

endmodule

// File: bench/tb_postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps

// Drives expressions into the evaluator and gives the verdict; checking happens
// in the result checker beside the block and in the assertions bound into it.
module tb_postfix_stack_evaluator_unit;

	import pse_pkg::*;

	// Operation codes the block does not define.
	localparam op_t OP_UNUSED_LO = 3'd5;
	localparam op_t OP_UNUSED_HI = 3'd7;

	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam int RANDOM_TOKENS  = 900;
	localparam int DRAIN_CYCLES   = 120;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} token_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic [2:0]  s_tuser  = OP_PUSH;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	int fail_count;
	int results_pending;
	int tokens_seen;
	int results_checked;

	token_t expr_tokens [$];
	int     tokens_sent;
	int     expressions_sent;
	int     send_calm;
	int     take_calm;
	int     results_taken;

	postfix_stack_evaluator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	postfix_result_checker #(
		.STACK_DEPTH (STACK_DEPTH_DEF)
	) result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.results_pending (results_pending),
		.tokens_seen     (tokens_seen),
		.results_checked (results_checked)
	);

	// Free-running clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Idle cycles before an item, with occasional stretches of none at all.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// Operand values weighted towards the limits, zero and small numbers.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return Q_ONE;
			4: return -Q_ONE;
			5, 6: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			7: return $urandom_range(0, 255) - 32'd128;
			default: return $urandom();
		endcase
	endfunction

	function automatic op_t pick_operator();
		return op_t'($urandom_range(OP_ADD, OP_DIV));
	endfunction

	task automatic add_token(op_t op, logic [31:0] value);
		token_t t;
		t.op    = op;
		t.value = value;
		expr_tokens.push_back(t);
	endtask

	// Sends the collected expression, marking its final item, then empties it.
	task automatic send_expression();
		int gap;
		for (int i = 0; i < expr_tokens.size(); i++) begin
			gap = draw_gap(send_calm);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser  <= expr_tokens[i].op;
			// Operator items carry random data, which the block must ignore.
			s_tdata  <= (expr_tokens[i].op == OP_PUSH) ? expr_tokens[i].value : $urandom();
			s_tlast  <= (i == expr_tokens.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			tokens_sent++;
		end
		expr_tokens.delete();
		expressions_sent++;
	endtask

	// A valid postfix expression with random values and operators.
	task automatic build_well_formed();
		int values_left;
		int depth;
		values_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
		depth = 0;
		while (values_left > 0 || depth > 1) begin
			if (values_left > 0 && (depth < 2 || $urandom_range(0, 1))) begin
				add_token(OP_PUSH, pick_value());
				values_left--;
				depth++;
			end else begin
				add_token(pick_operator(), $urandom());
				depth--;
			end
		end
	endtask

	// Arbitrary codes in arbitrary order, including the undefined ones.
	task automatic build_broken();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			add_token(op_t'($urandom_range(OP_PUSH, OP_UNUSED_HI)), pick_value());
		end
	endtask

	// Fills the stack to around its depth, past it at times, then folds a little.
	task automatic build_deep();
		int pushes;
		int folds;
		pushes = $urandom_range(STACK_DEPTH_DEF - 1, STACK_DEPTH_DEF + 3);
		folds  = $urandom_range(0, 3);
		repeat (pushes) add_token(OP_PUSH, pick_value());
		repeat (folds) add_token(pick_operator(), '0);
	endtask

	// Receiver: random stalls, and twice a long hold-off that backs up the block.
	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = draw_gap(take_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_taken++;
			if (results_taken == 12 || results_taken == 150) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int random_start;
		int kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Sum of the two largest values saturates.
		add_token(OP_PUSH, VAL_MAX);
		add_token(OP_PUSH, VAL_MAX);
		add_token(OP_ADD, '0);
		send_expression();
		// Smallest value minus one saturates low.
		add_token(OP_PUSH, Q_ONE);
		add_token(OP_PUSH, VAL_MIN);
		add_token(OP_SUB, '0);
		send_expression();
		// Division by zero with a positive and a negative dividend.
		add_token(OP_PUSH, '0);
		add_token(OP_PUSH, VAL_MAX);
		add_token(OP_DIV, '0);
		add_token(OP_PUSH, '0);
		add_token(OP_PUSH, VAL_MIN);
		add_token(OP_DIV, '0);
		add_token(OP_ADD, '0);
		send_expression();
		// Zero divided by zero gives zero.
		add_token(OP_PUSH, '0);
		add_token(OP_PUSH, '0);
		add_token(OP_DIV, '0);
		send_expression();
		// Operator with a single entry on the stack.
		add_token(OP_PUSH, Q_ONE);
		add_token(OP_MUL, '0);
		send_expression();
		// Undefined code alone: empty stack at the end.
		add_token(OP_UNUSED_HI, VAL_MAX);
		send_expression();
		// Undefined code first, then a saturating multiply: the first error sticks.
		add_token(OP_UNUSED_LO, '0);
		add_token(OP_PUSH, VAL_MIN);
		add_token(OP_PUSH, VAL_MIN);
		add_token(OP_MUL, '0);
		send_expression();
		// One push more than the stack holds.
		for (int i = 0; i <= STACK_DEPTH_DEF; i++) begin
			add_token(OP_PUSH, Q_ONE * i);
		end
		send_expression();

		// Random expressions, mostly well formed.
		random_start = tokens_sent;
		while (tokens_sent - random_start < RANDOM_TOKENS) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				build_well_formed();
			end else if (kind < 90) begin
				build_broken();
			end else begin
				build_deep();
			end
			send_expression();
		end
		s_tvalid <= 1'b0;

		// Let the last results come out, then give the block time to go quiet.
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items in %0d expressions; %0d results compared.",
			tokens_seen, expressions_sent, results_checked);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
